// File: rtl/addressable_led_bit_encoder_unit_macros.svh
`ifndef ADDRESSABLE_LED_BIT_ENCODER_UNIT_MACROS_SVH
`define ADDRESSABLE_LED_BIT_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ALED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ALED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/aled_pkg.sv
package aled_pkg;

   localparam int LEVEL_W     = 8;
   localparam int DUTY_W      = 16;
   localparam int COLOR_BITS  = 24;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [DUTY_W-1:0] ONE_DUTY_RESET  = 16'd60;
   localparam logic [DUTY_W-1:0] ZERO_DUTY_RESET = 16'd30;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_BIT_DUTY  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_BIT_DUTY = 1'b1;

   typedef struct packed {
      logic                  frame_start;
      logic [COLOR_BITS-1:0] color_word;
   } pixel_word_type;

   typedef struct packed {
      logic can_push;
      logic can_pop;
   } queue_status_type;

   // Exact floor(p / 255) for any product of two 8-bit levels.
   function automatic logic [LEVEL_W-1:0] scale_div255(input logic [2*LEVEL_W-1:0] p);
      logic [2*LEVEL_W:0] sum;
      sum = {1'b0, p} + {{(LEVEL_W+1){1'b0}}, p[2*LEVEL_W-1:LEVEL_W]} + 17'd1;
      return sum[2*LEVEL_W-1:LEVEL_W];
   endfunction

endpackage

// File: rtl/aled_req_if.sv
interface aled_req_if;
   logic                         valid;
   logic                         ready;
   logic [aled_pkg::LEVEL_W-1:0] red_level;
   logic [aled_pkg::LEVEL_W-1:0] green_level;
   logic [aled_pkg::LEVEL_W-1:0] blue_level;
   logic [aled_pkg::LEVEL_W-1:0] pixel_brightness;
   logic                         frame_start;

   modport source (
      output valid, red_level, green_level, blue_level, pixel_brightness, frame_start,
      input  ready
   );
   modport sink (
      input  valid, red_level, green_level, blue_level, pixel_brightness, frame_start,
      output ready
   );
endinterface

// File: rtl/aled_rsp_if.sv
interface aled_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [aled_pkg::DUTY_W-1:0] duty_value;
   logic                        run_last;

   modport source (
      output valid, duty_value, run_last,
      input  ready
   );
   modport sink (
      input  valid, duty_value, run_last,
      output ready
   );
endinterface

// File: rtl/aled_front.sv
module aled_front (
   input  logic                       clock,
   input  logic                       reset,
   aled_req_if.sink                   req_bus,
   input  aled_pkg::queue_status_type queue_status,
   output logic                       push,
   output aled_pkg::pixel_word_type   push_data
);

   localparam int PROD_W = 2 * aled_pkg::LEVEL_W;

   logic              s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0] red_prod_ff, red_prod_in;
   logic [PROD_W-1:0] green_prod_ff, green_prod_in;
   logic [PROD_W-1:0] blue_prod_ff, blue_prod_in;
   logic              frame_ff, frame_in;
   logic              accept;

   assign push           = s1_valid_ff && queue_status.can_push;
   assign req_bus.ready  = !s1_valid_ff || queue_status.can_push;
   assign accept         = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      red_prod_in   = red_prod_ff;
      green_prod_in = green_prod_ff;
      blue_prod_in  = blue_prod_ff;
      frame_in      = frame_ff;
      if (push) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in   = 1'b1;
         red_prod_in   = PROD_W'(req_bus.red_level) * PROD_W'(req_bus.pixel_brightness);
         green_prod_in = PROD_W'(req_bus.green_level) * PROD_W'(req_bus.pixel_brightness);
         blue_prod_in  = PROD_W'(req_bus.blue_level) * PROD_W'(req_bus.pixel_brightness);
         frame_in      = req_bus.frame_start;
      end
   end

   always_comb begin
      push_data.frame_start = frame_ff;
      push_data.color_word  = {aled_pkg::scale_div255(green_prod_ff),
                               aled_pkg::scale_div255(red_prod_ff),
                               aled_pkg::scale_div255(blue_prod_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      red_prod_ff   <= red_prod_in;
      green_prod_ff <= green_prod_in;
      blue_prod_ff  <= blue_prod_in;
      frame_ff      <= frame_in;
   end

endmodule

// File: rtl/aled_queue.sv
`include "addressable_led_bit_encoder_unit_macros.svh"

module aled_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  aled_pkg::pixel_word_type   push_data,
   input  logic                       pop,
   output aled_pkg::pixel_word_type   pop_data,
   output aled_pkg::queue_status_type queue_status
);

   localparam int DEPTH = aled_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   aled_pkg::pixel_word_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign queue_status.can_push = (count_ff != CNT_W'(DEPTH));
   assign queue_status.can_pop  = (count_ff != '0);
   assign pop_data              = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ALED_ASSERT_NOW(queue_no_overrun, clock, reset, push, queue_status.can_push || pop, "push into full queue")
   `ALED_ASSERT_NOW(queue_no_underrun, clock, reset, pop, queue_status.can_pop, "pop from empty queue")

endmodule

// File: rtl/aled_back.sv
`include "addressable_led_bit_encoder_unit_macros.svh"

module aled_back #(
   parameter int PAD_SLOTS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  aled_pkg::pixel_word_type          pop_data,
   input  aled_pkg::queue_status_type        queue_status,
   output logic                              pop,
   input  logic [aled_pkg::DUTY_W-1:0]       one_duty,
   input  logic [aled_pkg::DUTY_W-1:0]       zero_duty,
   aled_rsp_if.source                        rsp_bus
);

   localparam int COLOR_BITS = aled_pkg::COLOR_BITS;
   localparam int MAX_SLOTS  = (PAD_SLOTS > COLOR_BITS) ? PAD_SLOTS : COLOR_BITS;
   localparam int CNT_W      = $clog2(MAX_SLOTS);
   localparam int DUTY_W     = aled_pkg::DUTY_W;

   logic                  active_ff, active_in;
   logic                  pad_ff, pad_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [COLOR_BITS-1:0] word_ff, word_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]     duty_ff, duty_in;
   logic                  last_ff, last_in;
   logic                  advance, emit, last_bit;

   assign advance  = !rsp_valid_ff || rsp_bus.ready;
   assign emit     = advance && active_ff;
   assign last_bit = !pad_ff && (cnt_ff == CNT_W'(COLOR_BITS - 1));
   assign pop      = queue_status.can_pop && (!active_ff || (emit && last_bit));

   always_comb begin
      active_in    = active_ff;
      pad_in       = pad_ff;
      cnt_in       = cnt_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff;
      duty_in      = duty_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = active_ff;
      end
      if (emit) begin
         if (pad_ff) begin
            duty_in = '0;
            last_in = 1'b0;
            if (cnt_ff == CNT_W'(PAD_SLOTS - 1)) begin
               pad_in = 1'b0;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end else begin
            duty_in = word_ff[COLOR_BITS-1] ? one_duty : zero_duty;
            last_in = last_bit;
            word_in = word_ff << 1;
            cnt_in  = cnt_ff + 1'b1;
            if (last_bit) begin
               active_in = 1'b0;
            end
         end
      end
      if (pop) begin
         active_in = 1'b1;
         pad_in    = pop_data.frame_start && (PAD_SLOTS != 0);
         cnt_in    = '0;
         word_in   = pop_data.color_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pad_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pad_ff       <= pad_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff <= word_in;
      duty_ff <= duty_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.duty_value = duty_ff;
   assign rsp_bus.run_last   = last_ff;

   `ALED_ASSERT_NEXT(back_pad_slot_blank, clock, reset, emit && pad_ff, (duty_ff == '0) && !last_ff, "padding beat not blank")
   `ALED_ASSERT_NOW(back_pad_needs_pixel, clock, reset, pad_ff, active_ff, "padding without a pixel")
   `ALED_ASSERT_NOW(back_bit_count_range, clock, reset, active_ff && !pad_ff, cnt_ff < CNT_W'(COLOR_BITS), "bit counter out of range")

endmodule

// File: rtl/addressable_led_bit_encoder_unit.sv
// The first beat of a pixel passes the front-end product register, the queue entry, the
// back-end word register and the duty register. The back-end serializer emits one duty beat
// per cycle while rsp_bus.ready allows and reloads from the queue with no gap.
// Reset: synchronous, active high; clears all control state, empties the queue and sets the
// one-bit and zero-bit duty registers to 60 and 30.
module addressable_led_bit_encoder_unit #(
   parameter int PAD_SLOTS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   aled_req_if.sink                           req_bus,
   aled_rsp_if.source                         rsp_bus,
   input  logic                               csr_write_enable,
   input  logic [aled_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [aled_pkg::DUTY_W-1:0]        csr_write_data
);

   logic [aled_pkg::DUTY_W-1:0] one_duty_ff, one_duty_in;
   logic [aled_pkg::DUTY_W-1:0] zero_duty_ff, zero_duty_in;

   logic                       push;
   logic                       pop;
   aled_pkg::pixel_word_type   push_data;
   aled_pkg::pixel_word_type   pop_data;
   aled_pkg::queue_status_type queue_status;

   always_comb begin
      one_duty_in  = one_duty_ff;
      zero_duty_in = zero_duty_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            aled_pkg::REG_ONE_BIT_DUTY:  one_duty_in  = csr_write_data;
            aled_pkg::REG_ZERO_BIT_DUTY: zero_duty_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_duty_ff  <= aled_pkg::ONE_DUTY_RESET;
         zero_duty_ff <= aled_pkg::ZERO_DUTY_RESET;
      end else begin
         one_duty_ff  <= one_duty_in;
         zero_duty_ff <= zero_duty_in;
      end
   end

   aled_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   aled_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_data    (push_data),
      .pop          (pop),
      .pop_data     (pop_data),
      .queue_status (queue_status)
   );

   aled_back #(
      .PAD_SLOTS (PAD_SLOTS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_data     (pop_data),
      .queue_status (queue_status),
      .pop          (pop),
      .one_duty     (one_duty_ff),
      .zero_duty    (zero_duty_ff),
      .rsp_bus      (rsp_bus)
   );

endmodule

// File: tb/addressable_led_bit_encoder_unit_tb.sv
`timescale 1ns / 100ps

module addressable_led_bit_encoder_unit_tb;

   localparam int CLOCK_PERIOD   = 10;
   localparam int PAD_SLOTS      = 24;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LIMIT_CYCLES   = 1500000;
   localparam int DIRECTED_COUNT = 14;

   typedef struct packed {
      logic                            frame;
      logic [aled_pkg::LEVEL_W-1:0]    red;
      logic [aled_pkg::LEVEL_W-1:0]    green;
      logic [aled_pkg::LEVEL_W-1:0]    blue;
      logic [aled_pkg::LEVEL_W-1:0]    bright;
      logic                            known;
      logic [aled_pkg::COLOR_BITS-1:0] word;
   } pixel_row_type;

   typedef struct packed {
      logic [aled_pkg::DUTY_W-1:0] duty;
      logic                        last;
   } duty_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [aled_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [aled_pkg::DUTY_W-1:0] csr_write_data;

   aled_req_if req_bus();
   aled_rsp_if rsp_bus();

   addressable_led_bit_encoder_unit #(
      .PAD_SLOTS(PAD_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   duty_beat_type duty_beats_due[$];
   logic [aled_pkg::DUTY_W-1:0] one_duty_now = aled_pkg::ONE_DUTY_RESET;
   logic [aled_pkg::DUTY_W-1:0] zero_duty_now = aled_pkg::ZERO_DUTY_RESET;
   bit steady_flow = 1'b0;
   int error_count = 0;
   int cycle_count = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic logic [aled_pkg::LEVEL_W-1:0] scale_level(
         input logic [aled_pkg::LEVEL_W-1:0] level,
         input logic [aled_pkg::LEVEL_W-1:0] bright);
      logic [2*aled_pkg::LEVEL_W-1:0] product;
      product = {{aled_pkg::LEVEL_W{1'b0}}, level} * {{aled_pkg::LEVEL_W{1'b0}}, bright};
      return aled_pkg::LEVEL_W'(product / 16'd255);
   endfunction

   function automatic logic [aled_pkg::COLOR_BITS-1:0] pack_pixel(input pixel_row_type px);
      return {scale_level(px.green, px.bright), scale_level(px.red, px.bright),
              scale_level(px.blue, px.bright)};
   endfunction

   task automatic queue_duty_beats(input pixel_row_type px);
      logic [aled_pkg::COLOR_BITS-1:0] word;
      word = px.known ? px.word : pack_pixel(px);
      if (px.frame) begin
         for (int i = 0; i < PAD_SLOTS; i++) begin
            duty_beats_due.push_back('{duty: '0, last: 1'b0});
         end
      end
      for (int i = aled_pkg::COLOR_BITS - 1; i >= 0; i--) begin
         duty_beats_due.push_back('{duty: word[i] ? one_duty_now : zero_duty_now,
                                    last: (i == 0)});
      end
   endtask

   // Rows with a typed color word are checked against it; the rest use the predictor.
   function automatic pixel_row_type directed_row(input int n);
      case (n)
         0:  return {1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 24'h000000};
         1:  return {1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'hFFFFFF};
         2:  return {1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 24'h000000};
         3:  return {1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1, 24'h00FF00};
         4:  return {1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 24'hFF0000};
         5:  return {1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1, 24'h0000FF};
         6:  return {1'b0, 8'hA5, 8'h5A, 8'h3C, 8'hFF, 1'b1, 24'h5AA53C};
         7:  return {1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b1, 24'h010101};
         8:  return {1'b0, 8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 24'h000000};
         9:  return {1'b1, 8'hFE, 8'h01, 8'h7F, 8'hFE, 1'b0, 24'h000000};
         10: return {1'b0, 8'h01, 8'hFE, 8'hC3, 8'h7F, 1'b0, 24'h000000};
         11: return {1'b0, 8'h55, 8'hAA, 8'hFF, 8'hFE, 1'b0, 24'h000000};
         12: return {1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'hFFFFFF};
         default: return {1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000};
      endcase
   endfunction

   function automatic logic [aled_pkg::LEVEL_W-1:0] random_level();
      if ($urandom_range(0, 5) == 0) begin
         return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return aled_pkg::LEVEL_W'($urandom_range(0, 255));
   endfunction

   function automatic pixel_row_type random_pixel();
      pixel_row_type px;
      px = '0;
      px.frame = ($urandom_range(0, 4) == 0);
      px.red = random_level();
      px.green = random_level();
      px.blue = random_level();
      case ($urandom_range(0, 7))
         0: begin
            px.bright = 8'h00;
         end
         1, 2: begin
            px.bright = 8'hFF;
         end
         default: begin
            px.bright = aled_pkg::LEVEL_W'($urandom_range(0, 255));
         end
      endcase
      return px;
   endfunction

   task automatic hold_off(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_pixel(input pixel_row_type px);
      if (!steady_flow && $urandom_range(0, 3) == 0) begin
         hold_off($urandom_range(1, 15));
      end
      req_bus.valid <= 1'b1;
      req_bus.red_level <= px.red;
      req_bus.green_level <= px.green;
      req_bus.blue_level <= px.blue;
      req_bus.pixel_brightness <= px.bright;
      req_bus.frame_start <= px.frame;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      queue_duty_beats(px);
   endtask

   task automatic wait_for_results();
      if (duty_beats_due.size() != 0) begin
         req_bus.valid <= 1'b0;
         while (duty_beats_due.size() != 0) @(posedge clock);
      end
   endtask

   task automatic write_duty_registers(input logic [aled_pkg::DUTY_W-1:0] one_duty,
                                       input logic [aled_pkg::DUTY_W-1:0] zero_duty);
      csr_write_enable <= 1'b1;
      csr_index <= aled_pkg::REG_ONE_BIT_DUTY;
      csr_write_data <= one_duty;
      @(posedge clock);
      csr_index <= aled_pkg::REG_ZERO_BIT_DUTY;
      csr_write_data <= zero_duty;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      one_duty_now = one_duty;
      zero_duty_now = zero_duty;
   endtask

   task automatic next_phase(input logic [aled_pkg::DUTY_W-1:0] one_duty,
                             input logic [aled_pkg::DUTY_W-1:0] zero_duty,
                             input int pixel_count);
      int pause_at;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_duty_registers(one_duty, zero_duty);
      pause_at = $urandom_range(0, pixel_count - 1);
      for (int k = 0; k < pixel_count; k++) begin
         if (k == pause_at && !steady_flow) begin
            wait_for_results();
         end
         send_pixel(random_pixel());
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin : check_beats
      duty_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (duty_beats_due.size() == 0) begin
            report_mismatch("duty beat with none pending", rsp_bus.duty_value, 0);
         end else begin
            want = duty_beats_due.pop_front();
            if (rsp_bus.duty_value !== want.duty) begin
               report_mismatch("duty_value", rsp_bus.duty_value, want.duty);
            end
            if (rsp_bus.run_last !== want.last) begin
               report_mismatch("run_last", rsp_bus.run_last, want.last);
            end
         end
      end
   end

   initial begin : drive_ready
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!steady_flow && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(30, 80)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.red_level <= '0;
      req_bus.green_level <= '0;
      req_bus.blue_level <= '0;
      req_bus.pixel_brightness <= '0;
      req_bus.frame_start <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= aled_pkg::REG_ONE_BIT_DUTY;
      csr_write_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < DIRECTED_COUNT; n++) begin
         send_pixel(directed_row(n));
      end

      next_phase(16'hFFFF, 16'h0000, 40);
      next_phase(16'h0000, 16'hFFFF, 40);
      next_phase(16'hFFFF, 16'hFFFF, 20);
      repeat (3) begin
         next_phase(aled_pkg::DUTY_W'($urandom_range(0, 65535)),
                    aled_pkg::DUTY_W'($urandom_range(0, 65535)), 50);
      end
      steady_flow = 1'b1;
      next_phase(aled_pkg::DUTY_W'($urandom_range(0, 65535)),
                 aled_pkg::DUTY_W'($urandom_range(0, 65535)), 60);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/aled_pkg.sv
rtl/aled_req_if.sv
rtl/aled_rsp_if.sv
rtl/aled_front.sv
rtl/aled_queue.sv
rtl/aled_back.sv
rtl/addressable_led_bit_encoder_unit.sv
tb/addressable_led_bit_encoder_unit_tb.sv
